### rtl/core/jswd_pkg.sv
// shared types, codes and default sizes for the job slot work distributor
package jswd_pkg;

  localparam int NUM_SLOTS_DEF   = 8;
  localparam int MAX_HELPERS_DEF = 64;
  localparam int CHUNK_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    REQ_SUBMIT  = 3'd0,
    REQ_PICK    = 3'd1,
    REQ_FETCH   = 3'd2,
    REQ_LEAVE   = 3'd3,
    REQ_RELEASE = 3'd4
  } req_code_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NOWORK  = 3'd2,
    ST_DRAINED = 3'd3,
    ST_BUSY    = 3'd4,
    ST_NOTLIVE = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  slot_in;
    logic [15:0] chunk_count;
    logic        low_priority;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot_out;
    logic [15:0] chunk_index;
    logic        last_helper;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_rd;
    logic rd_slot;
    logic do_submit;
    logic do_exec;
    logic do_commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_code_t req_code;
    logic      scan_last;
  } stat_t;

endpackage

### rtl/core/jswd_datapath.sv
// slot table, pick scan and result register of the job slot work distributor
module jswd_datapath #(
  parameter int NUM_SLOTS   = jswd_pkg::NUM_SLOTS_DEF,
  parameter int MAX_HELPERS = jswd_pkg::MAX_HELPERS_DEF,
  parameter int CHUNK_BITS  = jswd_pkg::CHUNK_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  jswd_pkg::request_t request,
  input  jswd_pkg::cmd_t    cmd,
  output jswd_pkg::stat_t   stat,
  output logic              done,
  output jswd_pkg::result_t result
);
  import jswd_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int HW = $clog2(MAX_HELPERS + 1);
  localparam int CW = CHUNK_BITS;

  // latched request
  req_code_t       op;
  logic [SW-1:0]   slot_idx;
  logic            slot_ok;
  logic [CW-1:0]   cnt;
  logic            low_req;

  logic [NUM_SLOTS-1:0] live;
  logic [NUM_SLOTS-1:0] low_mark;
  logic [SW-1:0]        rotor;

  // slot memories, undefined until a submit writes them
  logic [CW-1:0] count_mem   [NUM_SLOTS];
  logic [CW-1:0] next_mem    [NUM_SLOTS];
  logic [HW-1:0] helpers_mem [NUM_SLOTS];
  logic [CW-1:0] count_rd;
  logic [CW-1:0] next_rd;
  logic [HW-1:0] helpers_rd;

  // pick scan
  logic [SW-1:0] scan_k;
  logic [SW:0]   scan_sum;
  logic [SW-1:0] scan_j;
  logic [SW-1:0] rd_addr;
  logic          eval_valid;
  logic [SW-1:0] eval_j;
  logic          eval_live;
  logic          eval_low;
  logic          cand;
  logic          better;
  logic          found;
  logic [SW-1:0] best_slot;
  logic [HW-1:0] best_h;
  logic          best_low;

  logic          free_found;
  logic [SW-1:0] free_slot;
  logic          addr_live;
  logic [SW-1:0] rotor_inc;

  logic          cnt_we;
  logic          next_we;
  logic          help_we;
  logic [CW-1:0] next_wd;
  logic [HW-1:0] help_wd;
  logic [SW-1:0] wr_addr;
  logic          live_set;
  logic          live_clr;
  logic          rotor_adv;
  result_t       res_next;

  assign stat.req_code  = req_code_t'(request.req_type);
  assign stat.scan_last = (scan_k == SW'(NUM_SLOTS - 1));

  // scan position wraps from the rotor
  assign scan_sum = {1'b0, rotor} + {1'b0, scan_k};
  assign scan_j   = (scan_sum >= (SW+1)'(NUM_SLOTS)) ?
                    SW'(scan_sum - (SW+1)'(NUM_SLOTS)) : scan_sum[SW-1:0];
  assign rd_addr  = cmd.scan_rd ? scan_j : slot_idx;

  assign rotor_inc = (rotor == SW'(NUM_SLOTS - 1)) ? '0 : rotor + SW'(1);
  assign addr_live = slot_ok && live[slot_idx];

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  // normal priority beats low, then fewer helpers; ties keep the earlier scan position
  assign cand   = eval_live && (next_rd < count_rd) && (32'(helpers_rd) < MAX_HELPERS);
  assign better = cand && (!found || (best_low && !eval_low) ||
                           (best_low == eval_low && helpers_rd < best_h));

  always_comb begin
    res_next  = '0;
    res_next.status = ST_OK;
    cnt_we    = 1'b0;
    next_we   = 1'b0;
    help_we   = 1'b0;
    next_wd   = '0;
    help_wd   = '0;
    wr_addr   = slot_idx;
    live_set  = 1'b0;
    live_clr  = 1'b0;
    rotor_adv = 1'b0;
    if (cmd.do_submit) begin
      wr_addr = free_slot;
      if (cnt == '0) begin
        res_next.status = ST_NOWORK;
      end else if (!free_found) begin
        res_next.status = ST_FULL;
      end else begin
        live_set = 1'b1;
        cnt_we   = 1'b1;
        next_we  = 1'b1;
        help_we  = 1'b1;
        res_next.slot_out = 3'(free_slot);
      end
    end else if (cmd.do_exec) begin
      if (!addr_live) begin
        res_next.status = ST_NOTLIVE;
      end else begin
        case (op)
          REQ_FETCH: begin
            if (next_rd >= count_rd) begin
              res_next.status = ST_DRAINED;
            end else begin
              res_next.chunk_index = 16'(next_rd);
              next_we = 1'b1;
              next_wd = next_rd + CW'(1);
            end
          end
          REQ_LEAVE: begin
            if (helpers_rd != '0) begin
              help_we = 1'b1;
              help_wd = helpers_rd - HW'(1);
              res_next.last_helper = (helpers_rd == HW'(1));
            end
          end
          REQ_RELEASE: begin
            if (helpers_rd != '0) begin
              res_next.status = ST_BUSY;
            end else begin
              live_clr = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd.do_commit) begin
      if (found) begin
        wr_addr   = best_slot;
        help_we   = 1'b1;
        help_wd   = best_h + HW'(1);
        rotor_adv = 1'b1;
        res_next.slot_out = 3'(best_slot);
      end else begin
        res_next.status = ST_NOWORK;
      end
    end
  end

  // memories: one write address, one registered read
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[wr_addr] <= cnt;
    end
    if (next_we) begin
      next_mem[wr_addr] <= next_wd;
    end
    if (help_we) begin
      helpers_mem[wr_addr] <= help_wd;
    end
    if (cmd.rd_slot || cmd.scan_rd) begin
      count_rd   <= count_mem[rd_addr];
      next_rd    <= next_mem[rd_addr];
      helpers_rd <= helpers_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= req_code_t'(request.req_type);
      slot_idx <= SW'(request.slot_in);
      slot_ok  <= (32'(request.slot_in) < NUM_SLOTS);
      cnt      <= CW'(request.chunk_count);
      low_req  <= request.low_priority;
    end
    eval_j    <= scan_j;
    eval_live <= live[scan_j];
    eval_low  <= low_mark[scan_j];
    if (eval_valid && better) begin
      best_slot <= eval_j;
      best_h    <= helpers_rd;
      best_low  <= eval_low;
    end
    if (cmd.do_submit || cmd.do_exec || cmd.do_commit) begin
      result <= res_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= '0;
      low_mark   <= '0;
      rotor      <= '0;
      scan_k     <= '0;
      eval_valid <= 1'b0;
      found      <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= cmd.do_submit || cmd.do_exec || cmd.do_commit;
      eval_valid <= cmd.scan_rd;
      if (live_set) begin
        live[wr_addr]     <= 1'b1;
        low_mark[wr_addr] <= low_req;
      end
      if (live_clr) begin
        live[slot_idx] <= 1'b0;
      end
      if (rotor_adv) begin
        rotor <= rotor_inc;
      end
      if (cmd.scan_clear) begin
        scan_k <= '0;
        found  <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_k <= scan_k + SW'(1);
        end
        if (eval_valid && better) begin
          found <= 1'b1;
        end
      end
    end
  end

  a_rotor_range: assert property (@(posedge clk) disable iff (rst)
    32'(rotor) < NUM_SLOTS)
    else $error("scan rotor out of range");

  a_rotor_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.do_commit && !found |=> $stable(rotor))
    else $error("rotor moved on a pick with no candidate");

  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.last_helper |-> result.status == ST_OK)
    else $error("last helper flagged on a failed request");

endmodule

### rtl/core/jswd_ctrl.sv
// sequencing state machine of the job slot work distributor
module jswd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  jswd_pkg::stat_t stat,
  output logic            busy,
  output jswd_pkg::cmd_t  cmd
);
  import jswd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SUBMIT = 7'b0000010,
    S_READ   = 7'b0000100,
    S_EXEC   = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_COMMIT = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load       = 1'b1;
          cmd.scan_clear = 1'b1;
          case (stat.req_code)
            REQ_SUBMIT: state_next = S_SUBMIT;
            REQ_PICK:   state_next = S_SCAN;
            REQ_FETCH, REQ_LEAVE, REQ_RELEASE: state_next = S_READ;
            default:    state_next = S_IDLE; // unknown request, no result
          endcase
        end
      end
      S_SUBMIT: begin
        cmd.do_submit = 1'b1;
        state_next    = S_IDLE;
      end
      S_READ: begin
        cmd.rd_slot = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        cmd.do_exec = 1'b1;
        state_next  = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last slot read is being judged
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.do_commit = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_pick_scans: assert property (@(posedge clk) disable iff (rst)
    start && !busy && stat.req_code == REQ_PICK |=> state == S_SCAN)
    else $error("pick request did not start a scan");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && stat.scan_last |=> state == S_DRAIN)
    else $error("scan ran past the last slot");

endmodule

### rtl/core/job_slot_work_distributor.sv
// top level of the job slot work distributor: controller plus slot datapath
//
//  channel   ports                  handshake
//  request   start, busy, request   taken when start is high and busy low
//  result    done, result           shown for one cycle while done is high
//
//  submit: after the request is taken, S_SUBMIT writes the slot and sets the result
//  fetch, leave, release: S_READ does the slot memory read, then S_EXEC the update
//  pick: S_SCAN reads one slot per cycle through the single read
//  port of the slot memories, then S_DRAIN and S_COMMIT do the helper count update
//  reset clears live marks and rotor at once; there is no clearing pass
//  an unknown request code is taken and gives no result; results cannot stall
module job_slot_work_distributor #(
  parameter int NUM_SLOTS   = jswd_pkg::NUM_SLOTS_DEF,
  parameter int MAX_HELPERS = jswd_pkg::MAX_HELPERS_DEF,
  parameter int CHUNK_BITS  = jswd_pkg::CHUNK_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  jswd_pkg::request_t request,
  output logic              done,
  output jswd_pkg::result_t result
);
  import jswd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  jswd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  jswd_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .MAX_HELPERS (MAX_HELPERS),
    .CHUNK_BITS  (CHUNK_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule
